>>> src/nirf_pkg.sv
// nirf_pkg: shared types, constants and the timing-window compare for the
// infrared frame decoder; no dependencies
`default_nettype none

package nirf_pkg;

    // widths
    localparam int DATA_BITS = 32;
    localparam int DUR_W     = 16;
    localparam int NOM_W     = 16;
    localparam int TOL_W     = 4;
    localparam int PROD_W    = NOM_W + 5;
    localparam int CMP_W     = (DUR_W > PROD_W - 4) ? DUR_W : PROD_W - 4;
    localparam int POS_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int VAR_W     = 2;
    localparam int ADDR_W    = 16;
    localparam int CMD_W     = 16;

    // frame positions
    localparam logic [POS_W-1:0] POS_MAX       = 7'd127;
    localparam logic [POS_W-1:0] POS_HDR_MARK  = 7'd1;
    localparam logic [POS_W-1:0] POS_HDR_SPACE = 7'd2;
    localparam logic [POS_W-1:0] POS_FIRST_BIT = 7'd3;
    localparam logic [POS_W-1:0] POS_STOP      = 7'd67;
    localparam logic [POS_W-1:0] POS_RPT_END   = 7'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_MARK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_SPACE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_SPACE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VENDOR     = 3'd7;

    // variant codes
    localparam logic [VAR_W-1:0] VAR_STD    = 2'd0;
    localparam logic [VAR_W-1:0] VAR_VENDOR = 2'd1;
    localparam logic [VAR_W-1:0] VAR_CMD16  = 2'd2;

    // classified duration, passed from front to back
    typedef struct packed {
        logic frame_end;
        logic hdr_mark;
        logic hdr_space;
        logic rpt_space;
        logic bit_mark;
        logic one_space;
        logic zero_space;
    } t_class;

    // one decoded result
    typedef struct packed {
        logic              ok;
        logic              rpt;
        logic [VAR_W-1:0]  variant;
        logic [ADDR_W-1:0] address;
        logic [CMD_W-1:0]  command;
    } t_result;

    // inclusive window nom*(16-tol)/16 .. nom*(16+tol)/16
    function automatic logic near_nom(input logic [DUR_W-1:0] d,
                                      input logic [NOM_W-1:0] nom,
                                      input logic [TOL_W-1:0] tol);
        logic [PROD_W-1:0] p_lo;
        logic [PROD_W-1:0] p_hi;
        logic [CMP_W-1:0]  lo;
        logic [CMP_W-1:0]  hi;
        logic [CMP_W-1:0]  dx;
        p_lo = PROD_W'(nom) * PROD_W'(5'd16 - {1'b0, tol});
        p_hi = PROD_W'(nom) * PROD_W'(5'd16 + {1'b0, tol});
        lo   = CMP_W'(p_lo[PROD_W-1:4]);
        hi   = CMP_W'(p_hi[PROD_W-1:4]);
        dx   = CMP_W'(d);
        return (dx >= lo) && (dx <= hi);
    endfunction

endpackage

`default_nettype wire

>>> src/nirf_front.sv
// nirf_front: configuration registers and duration classification against
// the timing windows; depends on nirf_pkg
`default_nettype none

module nirf_front
    import nirf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [NOM_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    input  wire logic [DUR_W-1:0]     i_duration,
    input  wire logic                 i_frame_end,
    input  wire logic                 i_q_full,
    output logic                      o_ready,
    output logic                      o_push,
    output t_class                    o_class,
    output logic [NOM_W-1:0]          o_vendor
);

    logic [NOM_W-1:0] r_hdr_mark, r_hdr_space, r_rpt_space;
    logic [NOM_W-1:0] r_bit_mark, r_one_space, r_zero_space, r_vendor;
    logic [TOL_W-1:0] r_tol;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_mark   <= NOM_W'(9000);
            r_hdr_space  <= NOM_W'(4500);
            r_rpt_space  <= NOM_W'(2250);
            r_bit_mark   <= NOM_W'(560);
            r_one_space  <= NOM_W'(1690);
            r_zero_space <= NOM_W'(560);
            r_tol        <= TOL_W'(4);
            r_vendor     <= NOM_W'(34798);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HDR_MARK:   r_hdr_mark   <= i_cfg_data;
                CFG_HDR_SPACE:  r_hdr_space  <= i_cfg_data;
                CFG_RPT_SPACE:  r_rpt_space  <= i_cfg_data;
                CFG_BIT_MARK:   r_bit_mark   <= i_cfg_data;
                CFG_ONE_SPACE:  r_one_space  <= i_cfg_data;
                CFG_ZERO_SPACE: r_zero_space <= i_cfg_data;
                CFG_TOLERANCE:  r_tol        <= i_cfg_data[TOL_W-1:0];
                CFG_VENDOR:     r_vendor     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request handshake into the queue
    assign o_ready  = !i_q_full;
    assign o_push   = i_valid && !i_q_full;
    assign o_vendor = r_vendor;

    // window compares for every nominal time
    always_comb begin
        o_class.frame_end  = i_frame_end;
        o_class.hdr_mark   = near_nom(i_duration, r_hdr_mark, r_tol);
        o_class.hdr_space  = near_nom(i_duration, r_hdr_space, r_tol);
        o_class.rpt_space  = near_nom(i_duration, r_rpt_space, r_tol);
        o_class.bit_mark   = near_nom(i_duration, r_bit_mark, r_tol);
        o_class.one_space  = near_nom(i_duration, r_one_space, r_tol);
        o_class.zero_space = near_nom(i_duration, r_zero_space, r_tol);
    end

endmodule

`default_nettype wire

>>> src/nirf_queue.sv
// nirf_queue: two-entry queue of classified durations between front and
// back; depends on nirf_pkg
`default_nettype none

module nirf_queue
    import nirf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_class i_class,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_class      o_class
);

    t_class     r_head, r_tail;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_class = r_head;

    // entry storage, the head always holds the oldest entry
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_head <= (r_count == 2'd2) ? r_tail : i_class;
        end else if (i_push && r_count == 2'd0) begin
            r_head <= i_class;
        end
        if (i_push && !i_pop && r_count == 2'd1) begin
            r_tail <= i_class;
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/nirf_back.sv
// nirf_back: frame position tracking, bit shifting, word decoding and the
// result output register; depends on nirf_pkg
`default_nettype none

module nirf_back
    import nirf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_class           i_class,
    input  wire logic [NOM_W-1:0] i_vendor,
    input  wire logic             i_out_ready,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output t_result               o_result
);

    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_err, n_err;
    logic                 r_rep, n_rep;
    logic [DATA_BITS-1:0] r_shift, n_shift;
    logic [ADDR_W-1:0]    r_last_addr, n_last_addr;
    logic [CMD_W-1:0]     r_last_cmd, n_last_cmd;
    logic [VAR_W-1:0]     r_last_var, n_last_var;
    logic                 r_out_valid, n_out_valid;
    t_result              r_res, n_res;
    t_result              dec;
    logic [7:0]           b0, b1, b2, b3;

    // take an entry unless a result is due and the output slot is blocked
    assign o_pop = i_q_valid && (!i_class.frame_end || !r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;

    // decode of the received word
    always_comb begin
        b0 = r_shift[7:0];
        b1 = r_shift[15:8];
        b2 = r_shift[23:16];
        b3 = r_shift[31:24];
        dec.ok  = 1'b1;
        dec.rpt = 1'b0;
        if (r_shift[15:0] == i_vendor) begin
            dec.variant = VAR_VENDOR;
            dec.address = ADDR_W'(b3);
            dec.command = CMD_W'(b2);
        end else begin
            dec.address = (b0 == ~b1) ? ADDR_W'(b0) : r_shift[15:0];
            if (b2 == ~b3) begin
                dec.variant = VAR_STD;
                dec.command = CMD_W'(b2);
            end else begin
                dec.variant = VAR_CMD16;
                dec.command = r_shift[31:16];
            end
        end
    end

    // frame state and result
    always_comb begin
        n_pos       = r_pos;
        n_err       = r_err;
        n_rep       = r_rep;
        n_shift     = r_shift;
        n_last_addr = r_last_addr;
        n_last_cmd  = r_last_cmd;
        n_last_var  = r_last_var;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_pop) begin
            if (r_pos == POS_HDR_MARK) begin
                if (!i_class.hdr_mark) begin
                    n_err = 1'b1;
                end
            end else if (r_pos == POS_HDR_SPACE) begin
                n_rep = !r_err && i_class.rpt_space;
                if (!i_class.hdr_space) begin
                    n_err = 1'b1;
                end
            end else if (r_pos >= POS_FIRST_BIT && r_pos <= POS_STOP) begin
                if (r_pos[0]) begin
                    // bit mark or stop mark
                    if (!i_class.bit_mark) begin
                        n_err = 1'b1;
                    end
                end else begin
                    // bit space, a one wins when both match
                    if (!i_class.one_space && !i_class.zero_space) begin
                        n_err = 1'b1;
                    end
                    n_shift = {i_class.one_space, r_shift[DATA_BITS-1:1]};
                end
            end

            if (i_class.frame_end) begin
                n_res       = '0;
                n_out_valid = 1'b1;
                if (r_pos == POS_RPT_END) begin
                    if (r_rep && i_class.bit_mark) begin
                        n_res.ok      = 1'b1;
                        n_res.rpt     = 1'b1;
                        n_res.variant = r_last_var;
                        n_res.address = r_last_addr;
                        n_res.command = r_last_cmd;
                    end
                end else if (r_pos == POS_STOP && !n_err) begin
                    n_res       = dec;
                    n_last_addr = dec.address;
                    n_last_cmd  = dec.command;
                    n_last_var  = dec.variant;
                end
                n_pos   = '0;
                n_err   = 1'b0;
                n_rep   = 1'b0;
                n_shift = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_err       <= 1'b0;
            r_rep       <= 1'b0;
            r_shift     <= '0;
            r_last_addr <= '0;
            r_last_cmd  <= '0;
            r_last_var  <= VAR_STD;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_err       <= n_err;
            r_rep       <= n_rep;
            r_shift     <= n_shift;
            r_last_addr <= n_last_addr;
            r_last_cmd  <= n_last_cmd;
            r_last_var  <= n_last_var;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

`ifndef NO_ASSERTIONS
    // a failed frame reports nothing but zeros
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.ok) |->
            (!r_res.rpt && r_res.variant == VAR_STD && r_res.address == '0
             && r_res.command == '0))
        else $error("failed frame with non-zero fields");

    // a repeat is always a success
    a_rpt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.rpt) |-> r_res.ok)
        else $error("repeat result not flagged ok");

    // a held result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_res)))
        else $error("stalled result changed");

    // position counts up by one until saturation within a frame
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_class.frame_end && r_pos != POS_MAX) |=>
            (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("position did not advance");
`endif

endmodule

`default_nettype wire

>>> src/nec_ir_frame_decoder_unit.sv
// NEC-style infrared frame decoder: one measured duration per request in,
// one result per frame end out.
// A result is registered when the frame tracker pops its frame-end duration.
// Throughput: one duration per cycle unless results stall, set by the combinational
// window compares and the two-entry queue between classifier and frame tracker.
// Reset (synchronous, active low): registers to defaults, frame and last values cleared.
`default_nettype none

module nec_ir_frame_decoder_unit
    import nirf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [NOM_W-1:0]     i_cfg_data,
    // duration stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,  // [15:0] duration_us
    input  wire logic                 s_axis_tlast,  // frame_end
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [39:0]               m_axis_tdata,  // [0] decoded_ok, [16:1] address,
                                                     // [32:17] command, zero above
    output logic [2:0]                m_axis_tuser   // [0] is_repeat, [2:1] variant
);

    t_class           f_class, q_class;
    logic             f_push, q_full, q_valid, b_pop;
    logic [NOM_W-1:0] vendor;
    t_result          res;

    nirf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_duration  (s_axis_tdata[DUR_W-1:0]),
        .i_frame_end (s_axis_tlast),
        .i_q_full    (q_full),
        .o_ready     (s_axis_tready),
        .o_push      (f_push),
        .o_class     (f_class),
        .o_vendor    (vendor)
    );

    nirf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_class (f_class),
        .i_pop   (b_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_class (q_class)
    );

    nirf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_class     (q_class),
        .i_vendor    (vendor),
        .i_out_ready (m_axis_tready),
        .o_pop       (b_pop),
        .o_out_valid (m_axis_tvalid),
        .o_result    (res)
    );

    // result packing
    assign m_axis_tdata = {7'd0, res.command, res.address, res.ok};
    assign m_axis_tuser = {res.variant, res.rpt};

endmodule

`default_nettype wire

>>> test/nec_ir_frame_decoder_unit_tb.sv
// testbench for nec_ir_frame_decoder_unit: drives pulse-duration frames through the
// stream port, predicts each frame-end result and compares it field by field
// depends on nirf_pkg and the decoder top level only

module nec_ir_frame_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nirf_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    // timing register set, one field per configuration register
    typedef struct packed {
        logic [15:0]      hdr_mark;
        logic [15:0]      hdr_space;
        logic [15:0]      rpt_space;
        logic [15:0]      bit_mark;
        logic [15:0]      one_space;
        logic [15:0]      zero_space;
        logic [TOL_W-1:0] tol;
        logic [15:0]      vendor;
    } t_ir_timing;

    localparam t_ir_timing NEC_TIMING = '{
        hdr_mark: 16'd9000, hdr_space: 16'd4500, rpt_space: 16'd2250,
        bit_mark: 16'd560, one_space: 16'd1690, zero_space: 16'd560,
        tol: 4'd4, vendor: 16'd34798
    };

    // frame tracker: mirrors the decoder state and holds the results owed
    class nec_frame_tracker;
        t_ir_timing      regs;
        logic [POS_W-1:0] pos;
        logic            bad_frame;
        logic            maybe_repeat;
        logic [31:0]     word;
        t_result         stored;
        t_result         due_results[$];
        int              mismatches;

        function new();
            regs         = NEC_TIMING;
            pos          = '0;
            bad_frame    = 1'b0;
            maybe_repeat = 1'b0;
            word         = '0;
            stored       = '0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
            case (idx)
                CFG_HDR_MARK:   regs.hdr_mark   = v;
                CFG_HDR_SPACE:  regs.hdr_space  = v;
                CFG_RPT_SPACE:  regs.rpt_space  = v;
                CFG_BIT_MARK:   regs.bit_mark   = v;
                CFG_ONE_SPACE:  regs.one_space  = v;
                CFG_ZERO_SPACE: regs.zero_space = v;
                CFG_TOLERANCE:  regs.tol        = v[TOL_W-1:0];
                CFG_VENDOR:     regs.vendor     = v;
                default: ;
            endcase
        endfunction

        // inclusive window around the nominal, in sixteenths
        function bit in_window(logic [15:0] d, logic [15:0] nom);
            int unsigned n;
            int unsigned t;
            int unsigned lo;
            int unsigned hi;
            n  = nom;
            t  = regs.tol;
            lo = n * (16 - t) / 16;
            hi = n * (16 + t) / 16;
            return (d >= lo) && (d <= hi);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // one accepted duration; a frame end owes exactly one result
        function void take_duration(logic [15:0] d, logic fin);
            t_result     r;
            logic        bit_val;
            logic [7:0]  b0;
            logic [7:0]  b1;
            logic [7:0]  b2;
            logic [7:0]  b3;

            if (pos == POS_HDR_MARK) begin
                if (!in_window(d, regs.hdr_mark))
                    bad_frame = 1'b1;
            end else if (pos == POS_HDR_SPACE) begin
                maybe_repeat = !bad_frame && in_window(d, regs.rpt_space);
                if (!in_window(d, regs.hdr_space))
                    bad_frame = 1'b1;
            end else if (pos >= POS_FIRST_BIT && pos <= POS_STOP) begin
                // marks at odd positions, bit spaces at even ones
                if (pos[0] == POS_FIRST_BIT[0]) begin
                    if (!in_window(d, regs.bit_mark))
                        bad_frame = 1'b1;
                end else begin
                    if (in_window(d, regs.one_space)) begin
                        bit_val = 1'b1;
                    end else if (in_window(d, regs.zero_space)) begin
                        bit_val = 1'b0;
                    end else begin
                        bit_val   = 1'b0;
                        bad_frame = 1'b1;
                    end
                    word = {bit_val, word[31:1]};
                end
            end

            if (!fin) begin
                if (pos != POS_MAX)
                    pos = pos + 1'b1;
                return;
            end

            r = '0;
            if (pos == POS_RPT_END) begin
                if (maybe_repeat && in_window(d, regs.bit_mark)) begin
                    r         = stored;
                    r.ok      = 1'b1;
                    r.rpt     = 1'b1;
                end
            end else if (pos == POS_STOP && !bad_frame) begin
                {b3, b2, b1, b0} = word;
                r.ok = 1'b1;
                if (word[15:0] == regs.vendor) begin
                    r.variant = VAR_VENDOR;
                    r.address = 16'(b3);
                    r.command = 16'(b2);
                end else begin
                    r.address = (b0 == ~b1) ? 16'(b0) : word[15:0];
                    if (b2 == ~b3) begin
                        r.variant = VAR_STD;
                        r.command = 16'(b2);
                    end else begin
                        r.variant = VAR_CMD16;
                        r.command = word[31:16];
                    end
                end
                stored     = r;
                stored.ok  = 1'b0;
                stored.rpt = 1'b0;
            end
            due_results.push_back(r);

            // frame state back to reset
            pos          = '0;
            bad_frame    = 1'b0;
            maybe_repeat = 1'b0;
            word         = '0;
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(logic [39:0] data, logic [2:0] user);
            t_result want;
            if (due_results.size() == 0) begin
                $error("result with no frame end owed: tdata %h tuser %h", data, user);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare("decoded_ok", want.ok, data[0]);
            compare("address", want.address, data[16:1]);
            compare("command", want.command, data[32:17]);
            compare("tdata_pad", 0, data[39:33]);
            compare("is_repeat", want.rpt, user[0]);
            compare("variant", want.variant, user[2:1]);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [NOM_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;
    logic [2:0]           m_axis_tuser;

    nec_frame_tracker tracker = new();
    t_ir_timing       cur = NEC_TIMING;
    logic [15:0]      frame_q[$];
    bit               idle_on = 1'b1;
    int               items_sent = 0;
    int               sink_hold = 0;

    nec_ir_frame_decoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] duration_us
        .s_axis_tlast  (s_axis_tlast),   // frame_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [0] decoded_ok, [16:1] address, [32:17] command
        .m_axis_tuser  (m_axis_tuser)    // [0] is_repeat, [2:1] variant
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // note every accepted duration request
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            tracker.take_duration(s_axis_tdata, s_axis_tlast);
    end

    // result side: check accepted results, stall in short bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_hold     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_result(m_axis_tdata, m_axis_tuser);
            if (sink_hold != 0) begin
                sink_hold     <= sink_hold - 1;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                sink_hold     <= $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // random duration inside the current window, edges favoured
    function automatic logic [15:0] pick_near(logic [15:0] nom);
        int unsigned n;
        int unsigned t;
        int unsigned lo;
        int unsigned hi;
        n  = nom;
        t  = cur.tol;
        lo = n * (16 - t) / 16;
        hi = n * (16 + t) / 16;
        if (hi > 65535)
            hi = 65535;
        case ($urandom_range(0, 7))
            0:       return 16'(lo);
            1:       return 16'(hi);
            default: return 16'($urandom_range(hi, lo));
        endcase
    endfunction

    // data word with a mix of checksum and vendor layouts
    function automatic logic [31:0] make_word();
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        case ($urandom_range(0, 4))
            0: begin
                b1 = ~b0;
                b3 = ~b2;
            end
            1: b3 = ~b2;
            2: b1 = ~b0;
            3: {b1, b0} = cur.vendor;
            default: ;
        endcase
        return {b3, b2, b1, b0};
    endfunction

    function automatic void build_data_frame(logic [31:0] w);
        frame_q.delete();
        frame_q.push_back(16'($urandom));
        frame_q.push_back(pick_near(cur.hdr_mark));
        frame_q.push_back(pick_near(cur.hdr_space));
        for (int i = 0; i < 32; i++) begin
            frame_q.push_back(pick_near(cur.bit_mark));
            frame_q.push_back(w[i] ? pick_near(cur.one_space) : pick_near(cur.zero_space));
        end
        frame_q.push_back(pick_near(cur.bit_mark));
    endfunction

    function automatic void build_repeat_frame();
        frame_q.delete();
        frame_q.push_back(16'($urandom));
        frame_q.push_back(pick_near(cur.hdr_mark));
        frame_q.push_back(pick_near(cur.rpt_space));
        frame_q.push_back(pick_near(cur.bit_mark));
    endfunction

    function automatic void build_noise(int n);
        frame_q.delete();
        repeat (n) frame_q.push_back(16'($urandom));
    endfunction

    // one duration request, with an optional gap in front
    task automatic push_duration(logic [15:0] d, logic fin);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            push_duration(frame_q[i], i == frame_q.size() - 1);
    endtask

    // hold the sender until every owed result has come back
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        tracker.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic apply_timing(t_ir_timing t);
        cur = t;
        cfg_write(CFG_HDR_MARK, t.hdr_mark);
        cfg_write(CFG_HDR_SPACE, t.hdr_space);
        cfg_write(CFG_RPT_SPACE, t.rpt_space);
        cfg_write(CFG_BIT_MARK, t.bit_mark);
        cfg_write(CFG_ONE_SPACE, t.one_space);
        cfg_write(CFG_ZERO_SPACE, t.zero_space);
        // unused upper bits of the tolerance write are random
        cfg_write(CFG_TOLERANCE, {12'($urandom), t.tol});
        cfg_write(CFG_VENDOR, t.vendor);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_ir_timing rand_timing();
        t_ir_timing t;
        t.hdr_mark   = 16'($urandom_range(100, 30000));
        t.hdr_space  = 16'($urandom_range(100, 30000));
        t.rpt_space  = 16'($urandom_range(100, 30000));
        t.bit_mark   = 16'($urandom_range(100, 30000));
        t.one_space  = 16'($urandom_range(100, 30000));
        t.zero_space = 16'($urandom_range(100, 30000));
        t.tol        = TOL_W'($urandom_range(0, 15));
        t.vendor     = 16'($urandom);
        return t;
    endfunction

    // mostly well-formed frames, the rest broken, truncated, padded or noise
    task automatic run_frames(int n_items, bit idling);
        int start;
        int pick;
        int cut;
        start = items_sent;
        while (items_sent - start < n_items) begin
            idle_on = idling && ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 99);
            if (pick < 45) begin
                build_data_frame(make_word());
            end else if (pick < 65) begin
                build_repeat_frame();
            end else if (pick < 80) begin
                build_data_frame(make_word());
                frame_q[$urandom_range(1, 67)] = 16'($urandom);
            end else if (pick < 88) begin
                build_data_frame(make_word());
                if ($urandom_range(0, 1) == 0) begin
                    cut = $urandom_range(1, 67);
                    while (frame_q.size() > cut) void'(frame_q.pop_back());
                end else begin
                    repeat ($urandom_range(1, 3)) frame_q.push_back(16'($urandom));
                end
            end else if (pick < 96) begin
                build_noise($urandom_range(1, 8));
            end else if (pick < 98) begin
                // long enough to saturate the position count
                build_noise($urandom_range(128, 134));
            end else begin
                build_repeat_frame();
                frame_q[$urandom_range(1, 3)] = 16'($urandom);
            end
            send_frame();
            if ($urandom_range(0, 29) == 0)
                wait_all_results();
        end
    endtask

    initial begin
        t_ir_timing t;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single-duration frames at the field extremes
        idle_on = 1'b1;
        frame_q = {16'h0000};
        send_frame();
        frame_q = {16'hFFFF};
        send_frame();
        // repeat before any data frame, all timings on the window edges
        frame_q = {16'hFFFF, 16'd6750, 16'd2812, 16'd700};
        send_frame();
        // repeat with header mark just under the window
        frame_q = {16'h0000, 16'd6749, 16'd2250, 16'd560};
        send_frame();
        // repeat with final bit mark just over the window
        frame_q = {16'h1234, 16'd11250, 16'd1687, 16'd701};
        send_frame();
        // four durations but a data header space
        frame_q = {16'h8001, 16'd9000, 16'd4500, 16'd560};
        send_frame();
        // wrong lengths around the repeat frame
        frame_q = {16'h5555, 16'd9000, 16'd2250};
        send_frame();
        frame_q = {16'hAAAA, 16'd9000, 16'd2250, 16'd560, 16'd560};
        send_frame();
        wait_all_results();

        // reset timing
        run_frames(400, 1'b1);
        wait_all_results();

        // random timing
        apply_timing(rand_timing());
        run_frames(250, 1'b1);
        wait_all_results();

        // low extreme: every window collapses to zero
        t = '{hdr_mark: 16'd0, hdr_space: 16'd0, rpt_space: 16'd0, bit_mark: 16'd0,
              one_space: 16'd0, zero_space: 16'd0, tol: 4'd0, vendor: 16'd0};
        apply_timing(t);
        run_frames(100, 1'b1);
        wait_all_results();

        // high extreme: widest windows, vendor word all ones
        t = '{hdr_mark: 16'hFFFF, hdr_space: 16'hFFFF, rpt_space: 16'hFFFF,
              bit_mark: 16'hFFFF, one_space: 16'hFFFF, zero_space: 16'hFFFF,
              tol: 4'd15, vendor: 16'hFFFF};
        apply_timing(t);
        run_frames(100, 1'b1);
        wait_all_results();

        // overlapping windows: ambiguous header space, spaces matching both bits
        t = '{hdr_mark: 16'd5000, hdr_space: 16'd3000, rpt_space: 16'd2800,
              bit_mark: 16'd400, one_space: 16'd1000, zero_space: 16'd900,
              tol: 4'd8, vendor: 16'($urandom)};
        apply_timing(t);
        run_frames(250, 1'b1);
        wait_all_results();

        // back to reset timing, no idling on either side
        apply_timing(NEC_TIMING);
        run_frames(350, 1'b0);
        idle_on = 1'b0;
        wait_all_results();

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
src/nirf_pkg.sv
src/nirf_front.sv
src/nirf_queue.sv
src/nirf_back.sv
src/nec_ir_frame_decoder_unit.sv
test/nec_ir_frame_decoder_unit_tb.sv
